// File: hdl/rvst_pkg.sv
// Shared types and constants of the reference-counted version slot table.
`default_nettype none

package rvst_pkg;

  localparam int VER_W = 63;
  localparam int CNT_W = 16;
  localparam int IDX_W = 6;

  typedef logic [VER_W-1:0] ver_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [2:0]       code_t;

  localparam code_t ACT_INIT    = 3'd0;
  localparam code_t ACT_ADD     = 3'd1;
  localparam code_t ACT_GET     = 3'd2;
  localparam code_t ACT_RELEASE = 3'd3;
  localparam code_t ACT_QUERY   = 3'd4;

  localparam code_t ST_OK         = 3'd0;
  localparam code_t ST_INIT_TWICE = 3'd1;
  localparam code_t ST_NOT_INIT   = 3'd2;
  localparam code_t ST_STALE      = 3'd3;
  localparam code_t ST_NO_SLOT    = 3'd4;
  localparam code_t ST_NOT_FOUND  = 3'd5;

  localparam ver_t VER_MAX = {VER_W{1'b1}};
  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};
  localparam cnt_t CNT_ONE = 16'd1;
  localparam cnt_t CNT_TWO = 16'd2;

  // Running summary that travels down the chain of slot cells.
  typedef struct packed {
    logic valid;
    logic match_found;
    idx_t match_pos;
    cnt_t match_refs;
    logic empty_found;
    idx_t empty_pos;
    logic pin_found;
    idx_t pin_pos;
    ver_t pin_tag;
    logic live_found;
    idx_t live_pos;
    ver_t live_tag;
    cnt_t live_refs;
  } scan_t;

  // Update broadcast to all cells when an item commits.
  typedef struct packed {
    logic we;
    idx_t idx;
    logic tag_we;
    ver_t tag;
    cnt_t refs;
  } wr_t;

endpackage

`default_nettype wire

// File: hdl/rvst_cell.sv
// One slot cell: holds a tag and a count and folds them into the passing scan summary.
`default_nettype none

module rvst_cell #(
  parameter int INDEX = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  rvst_pkg::ver_t      key,
  input  rvst_pkg::scan_t     scan_in,
  input  rvst_pkg::wr_t       wr,
  output rvst_pkg::scan_t     scan_out
);

  rvst_pkg::ver_t  tag;
  rvst_pkg::cnt_t  refs;
  rvst_pkg::scan_t acc;
  logic            live;
  rvst_pkg::idx_t  own;

  assign own  = rvst_pkg::IDX_W'(INDEX);
  assign live = (refs != '0);

  always_comb begin
    acc = scan_in;
    if (live && !acc.match_found && (tag == key)) begin
      acc.match_found = 1'b1;
      acc.match_pos   = own;
      acc.match_refs  = refs;
    end
    if (!live && !acc.empty_found) begin
      acc.empty_found = 1'b1;
      acc.empty_pos   = own;
    end
    // Strict compare keeps the lowest index among equal tags.
    if ((refs == rvst_pkg::CNT_ONE) && (!acc.pin_found || (tag < acc.pin_tag))) begin
      acc.pin_found = 1'b1;
      acc.pin_pos   = own;
      acc.pin_tag   = tag;
    end
    if (live && (!acc.live_found || (tag < acc.live_tag))) begin
      acc.live_found = 1'b1;
      acc.live_pos   = own;
      acc.live_tag   = tag;
      acc.live_refs  = refs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    if (scan_in.valid) begin
      scan_out.match_found <= acc.match_found;
      scan_out.match_pos   <= acc.match_pos;
      scan_out.match_refs  <= acc.match_refs;
      scan_out.empty_found <= acc.empty_found;
      scan_out.empty_pos   <= acc.empty_pos;
      scan_out.pin_found   <= acc.pin_found;
      scan_out.pin_pos     <= acc.pin_pos;
      scan_out.pin_tag     <= acc.pin_tag;
      scan_out.live_found  <= acc.live_found;
      scan_out.live_pos    <= acc.live_pos;
      scan_out.live_tag    <= acc.live_tag;
      scan_out.live_refs   <= acc.live_refs;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refs <= '0;
    end else if (wr.we && (wr.idx == own)) begin
      refs <= wr.refs;
    end
    if (wr.we && wr.tag_we && (wr.idx == own)) begin
      tag <= wr.tag;
    end
  end

endmodule

`default_nettype wire

// File: hdl/refcounted_version_slot_table_core.sv
// Top level of the reference-counted version slot table: control, chain of slot cells, result.
`default_nettype none

// Channel   Signals                                     Direction
// --------  ------------------------------------------  ---------
// in        in_valid, in_ready, action, version,         into block
//           take_reference
// out       out_valid, out_ready, status, slot_index,    out of block
//           version_out, count_out
//
// The result of each item waits on the summary token walking one slot cell per
// cycle down the chain from acceptance to the commit step.
// One item is in work at a time; the next item is accepted once the current one
// has committed, even while its result still waits in the output register.
// A stalled output holds the commit step until the output register is free.
// Synchronous reset empties every slot at once and clears the initialized flag.

module refcounted_version_slot_table_core #(
  parameter int SLOTS = 8
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire  [2:0]            action,
  input  wire  [62:0]           version,
  input  wire                   take_reference,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            status,
  output logic [5:0]            slot_index,
  output logic [62:0]           version_out,
  output logic [15:0]           count_out
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state;
  logic       start;
  logic       initialized;
  logic [63:0] latest_tag;

  // The item being worked on.
  rvst_pkg::code_t req_action;
  rvst_pkg::ver_t  req_key;
  logic            req_take;

  rvst_pkg::scan_t scan_bus [0:SLOTS];
  rvst_pkg::scan_t last;
  rvst_pkg::wr_t   wr;

  logic            accept;
  logic            commit;
  logic            stale;
  rvst_pkg::code_t res_status;
  rvst_pkg::idx_t  res_idx;
  rvst_pkg::ver_t  res_ver;
  rvst_pkg::cnt_t  res_cnt;
  logic            set_latest;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign commit   = (state == S_COMMIT) && (!out_valid || out_ready);

  // The token enters the chain with an empty summary.
  always_comb begin
    scan_bus[0]       = '0;
    scan_bus[0].valid = start;
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    rvst_cell #(
      .INDEX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .key      (req_key),
      .scan_in  (scan_bus[i]),
      .wr       (wr),
      .scan_out (scan_bus[i+1])
    );
  end

  // The last cell keeps its summary until the next token passes, so it is
  // still good while the commit waits on a stalled output.
  assign last = scan_bus[SLOTS];

  // A version is stale when it is not above the latest one; the all-ones reset
  // value of the latest tag stands for minus one, below every version.
  assign stale = !latest_tag[63] && (latest_tag[62:0] >= req_key);

  always_comb begin
    res_status = rvst_pkg::ST_OK;
    res_idx    = '0;
    res_ver    = '0;
    res_cnt    = '0;
    set_latest = 1'b0;
    wr         = '0;
    case (req_action)
      rvst_pkg::ACT_INIT: begin
        if (initialized) begin
          res_status = rvst_pkg::ST_INIT_TWICE;
        end else begin
          res_ver    = req_key;
          res_cnt    = rvst_pkg::CNT_ONE;
          set_latest = 1'b1;
          wr.we      = 1'b1;
          wr.tag_we  = 1'b1;
          wr.tag     = req_key;
          wr.refs    = rvst_pkg::CNT_ONE;
        end
      end
      rvst_pkg::ACT_ADD: begin
        if (!initialized) begin
          res_status = rvst_pkg::ST_NOT_INIT;
        end else if (stale) begin
          res_status = rvst_pkg::ST_STALE;
        end else if (!last.empty_found && !last.pin_found) begin
          res_status = rvst_pkg::ST_NO_SLOT;
        end else begin
          // An empty slot wins over replacing the oldest unpinned one.
          res_idx    = last.empty_found ? last.empty_pos : last.pin_pos;
          res_ver    = req_key;
          res_cnt    = req_take ? rvst_pkg::CNT_TWO : rvst_pkg::CNT_ONE;
          set_latest = 1'b1;
          wr.we      = 1'b1;
          wr.idx     = res_idx;
          wr.tag_we  = 1'b1;
          wr.tag     = req_key;
          wr.refs    = res_cnt;
        end
      end
      rvst_pkg::ACT_GET, rvst_pkg::ACT_RELEASE: begin
        if (!initialized) begin
          res_status = rvst_pkg::ST_NOT_INIT;
        end else if (!last.match_found) begin
          res_status = rvst_pkg::ST_NOT_FOUND;
          res_ver    = req_key;
        end else begin
          res_idx = last.match_pos;
          res_ver = req_key;
          if (req_action == rvst_pkg::ACT_RELEASE) begin
            res_cnt = last.match_refs - rvst_pkg::CNT_ONE;
          end else if (last.match_refs == rvst_pkg::CNT_MAX) begin
            res_cnt = last.match_refs;
          end else begin
            res_cnt = last.match_refs + rvst_pkg::CNT_ONE;
          end
          wr.we   = 1'b1;
          wr.idx  = last.match_pos;
          wr.refs = res_cnt;
        end
      end
      rvst_pkg::ACT_QUERY: begin
        if (last.live_found) begin
          res_idx = last.live_pos;
          res_ver = last.live_tag;
          res_cnt = last.live_refs;
        end else begin
          res_ver = rvst_pkg::VER_MAX;
        end
      end
      default: begin
        res_status = rvst_pkg::ST_OK;
      end
    endcase
    if (!commit) begin
      wr.we = 1'b0;
    end
  end

  // Control: accept, walk the chain, then commit and load the result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start       <= 1'b0;
      out_valid   <= 1'b0;
      initialized <= 1'b0;
      latest_tag  <= '1;
    end else begin
      start <= accept;
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (last.valid) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (commit && set_latest) begin
        latest_tag  <= {1'b0, req_key};
        initialized <= 1'b1;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_take   <= take_reference;
      // On a get, version zero stands for the latest version.
      if ((action == rvst_pkg::ACT_GET) && (version == '0)) begin
        req_key <= latest_tag[62:0];
      end else begin
        req_key <= version;
      end
    end
    if (commit) begin
      status      <= res_status;
      slot_index  <= res_idx;
      version_out <= res_ver;
      count_out   <= res_cnt;
    end
  end

  // An accepted item always starts a walk down the chain.
  a_accept_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN) && start)
    else $error("accepted item did not start a scan");

  // The summary only leaves the chain while the control waits for it.
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    last.valid |-> (state == S_SCAN))
    else $error("scan summary arrived outside the scan phase");

  // A result still waiting to be taken is never overwritten.
  a_commit_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT) && out_valid && !out_ready |=> (state == S_COMMIT) && out_valid)
    else $error("commit went ahead over a pending result");

  // Once initialized, the table stays initialized until reset.
  a_init_sticky: assert property (@(posedge clk) disable iff (rst)
    initialized |=> initialized)
    else $error("initialized flag dropped");

endmodule

`default_nettype wire
